// ===== hdl/turnout_sense_event_node_defines.svh =====
// Assertion macros shared by the turnout sense event node RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef TURNOUT_SENSE_EVENT_NODE_DEFINES_SVH
`define TURNOUT_SENSE_EVENT_NODE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSEN_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TSEN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tsen_pkg.sv =====
// Types and constants of the turnout sense event node.
// Depends on nothing; used by every module of the block.
package tsen_pkg;

  localparam int ID_W      = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = 1;

  typedef enum logic [2:0] {
    REQ_TICK     = 3'd0,
    REQ_REPORT   = 3'd1,
    REQ_PRODUCER = 3'd2,
    REQ_CONSUMER = 3'd3,
    REQ_GLOBAL   = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_UNKNOWN  = 2'd0,
    ST_NORMAL   = 2'd1,
    ST_REVERSED = 2'd2
  } turn_state_t;

  typedef enum logic [1:0] {
    K_REPORT   = 2'd0,
    K_PRODUCER = 2'd1,
    K_CONSUMER = 2'd2,
    K_MOTOR    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    V_VALID   = 2'd0,
    V_INVALID = 2'd1,
    V_UNKNOWN = 2'd2
  } validity_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_NORMAL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_REVERSED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_NORMAL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_REVERSED = 3'd3;

  typedef enum logic [1:0] {
    GS_PROD_NORMAL   = 2'd0,
    GS_PROD_REVERSED = 2'd1,
    GS_CONS_NORMAL   = 2'd2,
    GS_CONS_REVERSED = 2'd3
  } glb_step_t;

  typedef struct packed {
    logic [ID_W-1:0] motor_normal_id;
    logic [ID_W-1:0] motor_reversed_id;
    logic [ID_W-1:0] points_normal_id;
    logic [ID_W-1:0] points_reversed_id;
  } cfg_regs_t;

  typedef struct packed {
    logic            glb;
    kind_t           kind;
    validity_t       validity;
    logic [ID_W-1:0] id;
    logic            motor_a;
    logic            motor_b;
    validity_t       prod_n;
    validity_t       prod_r;
    validity_t       cons_n;
    validity_t       cons_r;
  } cmd_t;

  typedef struct packed {
    kind_t           kind;
    validity_t       validity;
    logic [ID_W-1:0] id;
    logic            motor_a;
    logic            motor_b;
    logic            last;
  } res_t;

  function automatic validity_t pair_normal(turn_state_t st);
    validity_t v;
    case (st)
      ST_NORMAL:   v = V_VALID;
      ST_REVERSED: v = V_INVALID;
      default:     v = V_UNKNOWN;
    endcase
    return v;
  endfunction

  function automatic validity_t pair_reversed(turn_state_t st);
    validity_t v;
    case (st)
      ST_NORMAL:   v = V_INVALID;
      ST_REVERSED: v = V_VALID;
      default:     v = V_UNKNOWN;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/tsen_front.sv =====
// Front end: accepts requests, keeps points and motor state, classifies work.
// Depends on tsen_pkg; feeds commands into tsen_cmdq.
`include "turnout_sense_event_node_defines.svh"
module tsen_front #(
  parameter int DEBOUNCE_TICKS = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [2:0]          req_type,
  input  logic                sense_a,
  input  logic                sense_b,
  input  logic [63:0]         event_id,
  input  logic                for_other_node,
  input  tsen_pkg::cfg_regs_t cfg,
  input  logic                q_full,
  output logic                q_push,
  output tsen_pkg::cmd_t      cmd
);
  import tsen_pkg::*;

  localparam int CNT_W = $clog2(DEBOUNCE_TICKS + 1);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(DEBOUNCE_TICKS);

  turn_state_t      points_r, points_nxt;
  turn_state_t      motor_r, motor_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  turn_state_t      sensed;
  logic             accept;
  logic             emit;
  logic             settle;
  req_t             req;

  assign req     = req_t'(req_type);
  assign accept  = push && !q_full;
  assign cnt_inc = cnt_r + CNT_W'(1);
  assign settle  = accept && req == REQ_TICK && sensed != points_r && cnt_inc >= CNT_LIMIT;

  always_comb begin
    if (!sense_a && sense_b) begin
      sensed = ST_NORMAL;
    end else if (sense_a && !sense_b) begin
      sensed = ST_REVERSED;
    end else begin
      sensed = ST_UNKNOWN;
    end
  end

  always_comb begin
    points_nxt   = points_r;
    motor_nxt    = motor_r;
    cnt_nxt      = cnt_r;
    emit         = 1'b0;
    cmd.glb      = 1'b0;
    cmd.kind     = K_REPORT;
    cmd.validity = V_VALID;
    cmd.id       = event_id;
    unique case (req)
      REQ_TICK: begin
        if (sensed == points_r) begin
          cnt_nxt = '0;
        end else if (cnt_inc >= CNT_LIMIT) begin
          cnt_nxt    = '0;
          points_nxt = sensed;
          if (sensed == ST_NORMAL && cfg.points_normal_id != '0) begin
            emit   = 1'b1;
            cmd.id = cfg.points_normal_id;
          end else if (sensed == ST_REVERSED && cfg.points_reversed_id != '0) begin
            emit   = 1'b1;
            cmd.id = cfg.points_reversed_id;
          end
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      REQ_REPORT: begin
        cmd.kind = K_MOTOR;
        if (event_id == cfg.motor_normal_id) begin
          motor_nxt = ST_NORMAL;
          emit      = 1'b1;
        end else if (event_id == cfg.motor_reversed_id) begin
          motor_nxt = ST_REVERSED;
          emit      = 1'b1;
        end
      end
      REQ_PRODUCER: begin
        emit     = 1'b1;
        cmd.kind = K_PRODUCER;
        if ((event_id == cfg.points_normal_id && points_r == ST_NORMAL) ||
            (event_id == cfg.points_reversed_id && points_r == ST_REVERSED)) begin
          cmd.validity = V_VALID;
        end else begin
          cmd.validity = V_INVALID;
        end
      end
      REQ_CONSUMER: begin
        emit     = 1'b1;
        cmd.kind = K_CONSUMER;
        if ((event_id == cfg.motor_normal_id && motor_r == ST_NORMAL) ||
            (event_id == cfg.motor_reversed_id && motor_r == ST_REVERSED)) begin
          cmd.validity = V_VALID;
        end else begin
          cmd.validity = V_UNKNOWN;
        end
      end
      REQ_GLOBAL: begin
        emit    = !for_other_node;
        cmd.glb = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    cmd.motor_a = (motor_nxt == ST_NORMAL);
    cmd.motor_b = (motor_nxt == ST_REVERSED);
    cmd.prod_n  = pair_normal(points_r);
    cmd.prod_r  = pair_reversed(points_r);
    cmd.cons_n  = pair_normal(motor_r);
    cmd.cons_r  = pair_reversed(motor_r);
  end

  assign q_push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r <= ST_UNKNOWN;
      motor_r  <= ST_UNKNOWN;
      cnt_r    <= '0;
    end else if (accept) begin
      points_r <= points_nxt;
      motor_r  <= motor_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `TSEN_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r < CNT_LIMIT, "debounce count out of range")
  `TSEN_ASSERT_NEXT(a_points_settle, clk, rst_n, settle, cnt_r == '0, "debounce count not cleared")

endmodule

// ===== hdl/tsen_cmdq.sv =====
// Short command queue between the front end and the back end.
// Depends on tsen_pkg.
`include "turnout_sense_event_node_defines.svh"
module tsen_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  tsen_pkg::cmd_t wr_cmd,
  input  logic           pop,
  output logic           avail,
  output tsen_pkg::cmd_t head
);
  import tsen_pkg::*;

  cmd_t               mem [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_AW:0]   count_r, count_nxt;
  logic               do_pop;

  assign full   = (count_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign avail  = (count_r != '0);
  assign do_pop = pop && avail;
  assign head   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + CMDQ_AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + CMDQ_AW'(1);
    end
    if (push && !do_pop) begin
      count_nxt = count_r + (CMDQ_AW+1)'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - (CMDQ_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `TSEN_ASSERT_NOW(a_q_bound, clk, rst_n, 1'b1, count_r <= (CMDQ_AW+1)'(CMDQ_DEPTH), "queue overrun")
  `TSEN_ASSERT_NOW(a_q_no_push_full, clk, rst_n, full, !push, "push into a full command queue")

endmodule

// ===== hdl/tsen_back.sv =====
// Back end: expands queued commands into result messages held in an output register.
// Depends on tsen_pkg; drains tsen_cmdq.
`include "turnout_sense_event_node_defines.svh"
module tsen_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                avail,
  input  tsen_pkg::cmd_t      head,
  input  tsen_pkg::cfg_regs_t cfg,
  output logic                cmd_pop,
  input  logic                res_pop,
  output logic                res_vld,
  output tsen_pkg::res_t      res
);
  import tsen_pkg::*;

  glb_step_t step_r, step_nxt;
  logic      vld_r;
  res_t      res_r, res_nxt;
  logic      load;

  assign load    = avail && (!vld_r || res_pop);
  assign res_vld = vld_r;
  assign res     = res_r;

  always_comb begin
    res_nxt.motor_a = head.motor_a;
    res_nxt.motor_b = head.motor_b;
    res_nxt.kind     = head.kind;
    res_nxt.validity = head.validity;
    res_nxt.id       = head.id;
    res_nxt.last     = 1'b1;
    step_nxt         = step_r;
    cmd_pop          = load;
    if (head.glb) begin
      res_nxt.last = (step_r == GS_CONS_REVERSED);
      cmd_pop      = load && (step_r == GS_CONS_REVERSED);
      if (load) begin
        step_nxt = glb_step_t'(step_r + 2'd1);
      end
      unique case (step_r)
        GS_PROD_NORMAL: begin
          res_nxt.kind     = K_PRODUCER;
          res_nxt.validity = head.prod_n;
          res_nxt.id       = cfg.points_normal_id;
        end
        GS_PROD_REVERSED: begin
          res_nxt.kind     = K_PRODUCER;
          res_nxt.validity = head.prod_r;
          res_nxt.id       = cfg.points_reversed_id;
        end
        GS_CONS_NORMAL: begin
          res_nxt.kind     = K_CONSUMER;
          res_nxt.validity = head.cons_n;
          res_nxt.id       = cfg.motor_normal_id;
        end
        default: begin
          res_nxt.kind     = K_CONSUMER;
          res_nxt.validity = head.cons_r;
          res_nxt.id       = cfg.motor_reversed_id;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      step_r <= GS_PROD_NORMAL;
    end else begin
      if (load) begin
        vld_r <= 1'b1;
      end else if (res_pop) begin
        vld_r <= 1'b0;
      end
      step_r <= step_nxt;
    end
  end

  `TSEN_ASSERT_NOW(a_step_global, clk, rst_n, step_r != GS_PROD_NORMAL, avail && head.glb, "global expansion without a global command")
  `TSEN_ASSERT_NEXT(a_single_last, clk, rst_n, load && !head.glb, vld_r && res_r.last, "single result not marked last")

endmodule

// ===== hdl/turnout_sense_event_node.sv =====
// Top level of the turnout sense event node: configuration registers and wiring.
// Depends on tsen_pkg, tsen_front, tsen_cmdq and tsen_back.
//
//   Channel  Handshake            Moves
//   in_      push / full          one request transaction
//   out_     empty / pop          one result message transaction
//   cfg_     valid / ready        one register write transaction
//
// A request is taken in any cycle the two-entry command queue is not full.
// Tick, report and single identify results pass the queue, then the output register.
// A global identify occupies the back end for four messages, the last marked last.
// A stalled result output backs up the command queue and then raises in_full.
// Reset is synchronous and active low; the configuration port is always ready.
module turnout_sense_event_node #(
  parameter int DEBOUNCE_TICKS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_req_type,
  input  logic        in_sense_a,
  input  logic        in_sense_b,
  input  logic [63:0] in_event_id,
  input  logic        in_for_other_node,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_msg_kind,
  output logic [1:0]  out_validity,
  output logic [63:0] out_event_id,
  output logic        out_motor_a,
  output logic        out_motor_b,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [tsen_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0] cfg_data
);
  import tsen_pkg::*;

  cfg_regs_t cfg_r;
  logic      q_push;
  logic      q_full;
  cmd_t      fr_cmd;
  cmd_t      q_head;
  logic      q_avail;
  logic      q_pop;
  logic      res_vld;
  res_t      res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MOTOR_NORMAL:    cfg_r.motor_normal_id    <= cfg_data;
        CFG_MOTOR_REVERSED:  cfg_r.motor_reversed_id  <= cfg_data;
        CFG_POINTS_NORMAL:   cfg_r.points_normal_id   <= cfg_data;
        CFG_POINTS_REVERSED: cfg_r.points_reversed_id <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tsen_front #(
    .DEBOUNCE_TICKS(DEBOUNCE_TICKS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (in_push),
    .req_type       (in_req_type),
    .sense_a        (in_sense_a),
    .sense_b        (in_sense_b),
    .event_id       (in_event_id),
    .for_other_node (in_for_other_node),
    .cfg            (cfg_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .cmd            (fr_cmd)
  );

  tsen_cmdq u_cmdq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .full   (q_full),
    .wr_cmd (fr_cmd),
    .pop    (q_pop),
    .avail  (q_avail),
    .head   (q_head)
  );

  tsen_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .avail   (q_avail),
    .head    (q_head),
    .cfg     (cfg_r),
    .cmd_pop (q_pop),
    .res_pop (out_pop),
    .res_vld (res_vld),
    .res     (res)
  );

  assign in_full      = q_full;
  assign out_empty    = !res_vld;
  assign out_msg_kind = res.kind;
  assign out_validity = res.validity;
  assign out_event_id = res.id;
  assign out_motor_a  = res.motor_a;
  assign out_motor_b  = res.motor_b;
  assign out_last     = res.last;

endmodule
